// ----- rtl/bts_pkg.sv -----
package bts_pkg;

   // Field and port widths
   localparam int NOW_W      = 32;
   localparam int NBR_W      = 8;
   localparam int ENT_W      = 32;
   localparam int GAP_W      = 31;
   localparam int WIN_W      = 32;
   localparam int CNT8_W     = 8;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // Bit-serial remainder unit: one dividend bit per step
   localparam int DIV_STEPS = ENT_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_INTERVAL      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_JITTER_MAX    = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_STARTUP_WIN   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_BURST_LEN     = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_SUPPRESS_NBRS = 3'd4;

   // Register reset values
   localparam logic [GAP_W-1:0]  RST_INTERVAL      = 31'd60000;
   localparam logic [GAP_W-1:0]  RST_JITTER_MAX    = 31'd5000;
   localparam logic [WIN_W-1:0]  RST_STARTUP_WIN   = 32'd10000;
   localparam logic [CNT8_W-1:0] RST_BURST_LEN     = 8'd3;
   localparam logic [CNT8_W-1:0] RST_SUPPRESS_NBRS = 8'd4;

   // Operation codes carried in req_tuser
   localparam logic OP_RECORD = 1'b0;
   localparam logic OP_TICK   = 1'b1;

   typedef enum logic [1:0] {
      DEC_STARTUP   = 2'd0,
      DEC_SCHEDULED = 2'd1,
      DEC_NEIGHBORS = 2'd2,
      DEC_INTERVAL  = 2'd3
   } decision_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic record;
      logic check;
      logic decide;
      logic div_step;
      logic commit;
      logic emit;
   } dp_cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic op_tick;
      logic send;
      logic jitter_off;
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage

// ----- rtl/bts_ctrl.sv -----
module bts_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   output bts_pkg::dp_cmd_type    cmd,
   input  bts_pkg::dp_status_type status
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_DECIDE,
      S_DIV,
      S_COMMIT,
      S_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and datapath commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (status.op_tick) begin
               cmd.check = 1'b1;
               state_in  = S_DECIDE;
            end else begin
               cmd.record = 1'b1;
               state_in   = S_IDLE;
            end
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            if (!status.send) begin
               state_in = S_EMIT;
            end else if (status.jitter_off) begin
               state_in = S_COMMIT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/bts_dp.sv -----
module bts_dp (
   input  logic                                clock,
   input  logic                                reset,
   input  bts_pkg::dp_cmd_type                 cmd,
   output bts_pkg::dp_status_type              status,
   input  logic [bts_pkg::REQ_DATA_W-1:0]      req_tdata,
   input  logic                                req_tuser,
   input  logic                                csr_we,
   input  logic [bts_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [bts_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [bts_pkg::RSP_DATA_W-1:0]      rsp_tdata
);

   // Configuration registers
   logic [bts_pkg::GAP_W-1:0]  interval_ff;
   logic [bts_pkg::GAP_W-1:0]  jitter_max_ff;
   logic [bts_pkg::WIN_W-1:0]  window_ff;
   logic [bts_pkg::CNT8_W-1:0] burst_len_ff;
   logic [bts_pkg::CNT8_W-1:0] suppress_ff;

   // Scheduler state
   logic                       startup_over_ff;
   logic [bts_pkg::CNT8_W-1:0] burst_sent_ff;
   logic [bts_pkg::NOW_W-1:0]  last_send_ff;
   logic [bts_pkg::NOW_W-1:0]  min_gap_ff;

   // Latched word
   logic                       op_ff;
   logic [bts_pkg::NOW_W-1:0]  now_ff;
   logic [bts_pkg::NBR_W-1:0]  nbr_ff;
   logic [bts_pkg::ENT_W-1:0]  entropy_ff;

   // Check stage results
   logic                       window_hit_ff;
   logic [bts_pkg::NOW_W-1:0]  elapsed_ff;

   // Decision and remainder unit
   bts_pkg::decision_type      decision_ff;
   bts_pkg::decision_type      decision_in;
   logic                       send_in;
   logic                       burst_closed;
   logic [bts_pkg::CNT8_W-1:0] burst_inc;
   logic [bts_pkg::GAP_W-1:0]  rem_ff;
   logic [bts_pkg::ENT_W-1:0]  dvd_ff;
   logic [bts_pkg::DIV_CNT_W-1:0] div_cnt_ff;
   logic [bts_pkg::GAP_W:0]    trial;
   logic [bts_pkg::GAP_W:0]    trial_diff;
   logic                       trial_fits;

   // Output register
   logic                       rsp_valid_ff;
   bts_pkg::decision_type      rsp_dec_ff;

   // Configuration writes; unknown indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff   <= bts_pkg::RST_INTERVAL;
         jitter_max_ff <= bts_pkg::RST_JITTER_MAX;
         window_ff     <= bts_pkg::RST_STARTUP_WIN;
         burst_len_ff  <= bts_pkg::RST_BURST_LEN;
         suppress_ff   <= bts_pkg::RST_SUPPRESS_NBRS;
      end else if (csr_we) begin
         unique case (csr_addr)
            bts_pkg::REG_INTERVAL:      interval_ff   <= csr_wdata[bts_pkg::GAP_W-1:0];
            bts_pkg::REG_JITTER_MAX:    jitter_max_ff <= csr_wdata[bts_pkg::GAP_W-1:0];
            bts_pkg::REG_STARTUP_WIN:   window_ff     <= csr_wdata[bts_pkg::WIN_W-1:0];
            bts_pkg::REG_BURST_LEN:     burst_len_ff  <= csr_wdata[bts_pkg::CNT8_W-1:0];
            bts_pkg::REG_SUPPRESS_NBRS: suppress_ff   <= csr_wdata[bts_pkg::CNT8_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Input word capture and the wide compare/subtract of the check stage
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff      <= req_tuser;
         now_ff     <= req_tdata[31:0];
         nbr_ff     <= req_tdata[39:32];
         entropy_ff <= req_tdata[71:40];
      end
      if (cmd.check) begin
         window_hit_ff <= (now_ff >= window_ff);
         elapsed_ff    <= now_ff - last_send_ff;
      end
   end

   // Tick decision from the check stage results and the current state
   assign burst_closed = startup_over_ff || window_hit_ff || (burst_sent_ff >= burst_len_ff);
   assign burst_inc    = burst_sent_ff + 8'd1;

   always_comb begin
      priority if (!burst_closed) begin
         decision_in = bts_pkg::DEC_STARTUP;
         send_in     = 1'b1;
      end else if (nbr_ff >= suppress_ff) begin
         decision_in = bts_pkg::DEC_NEIGHBORS;
         send_in     = 1'b0;
      end else if ((last_send_ff != '0) && (elapsed_ff < min_gap_ff)) begin
         decision_in = bts_pkg::DEC_INTERVAL;
         send_in     = 1'b0;
      end else begin
         decision_in = bts_pkg::DEC_SCHEDULED;
         send_in     = 1'b1;
      end
   end

   // One restoring step of entropy mod jitter_max per cycle
   assign trial      = {rem_ff, dvd_ff[bts_pkg::ENT_W-1]};
   assign trial_diff = trial - {1'b0, jitter_max_ff};
   assign trial_fits = (trial >= {1'b0, jitter_max_ff});

   always_ff @(posedge clock) begin
      if (cmd.decide) begin
         decision_ff <= decision_in;
         rem_ff      <= '0;
         dvd_ff      <= entropy_ff;
         div_cnt_ff  <= '0;
      end else if (cmd.div_step) begin
         rem_ff     <= trial_fits ? trial_diff[bts_pkg::GAP_W-1:0] : trial[bts_pkg::GAP_W-1:0];
         dvd_ff     <= {dvd_ff[bts_pkg::ENT_W-2:0], 1'b0};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // Scheduler state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         startup_over_ff <= 1'b0;
         burst_sent_ff   <= '0;
         last_send_ff    <= '0;
         min_gap_ff      <= '0;
      end else begin
         if (cmd.record) begin
            last_send_ff <= now_ff;
         end
         if (cmd.decide) begin
            if (!burst_closed) begin
               burst_sent_ff   <= burst_inc;
               startup_over_ff <= (burst_inc >= burst_len_ff);
            end else begin
               startup_over_ff <= 1'b1;
            end
         end
         if (cmd.commit) begin
            last_send_ff <= now_ff;
            min_gap_ff   <= {1'b0, interval_ff} + {1'b0, rem_ff};
         end
      end
   end

   // Output register: holds a finished word until the sink takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_dec_ff <= decision_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_dec_ff};

   // Status back to the controller
   assign status.op_tick    = (op_ff == bts_pkg::OP_TICK);
   assign status.send       = send_in;
   assign status.jitter_off = (jitter_max_ff == '0);
   assign status.div_done   = (div_cnt_ff == bts_pkg::DIV_CNT_W'(bts_pkg::DIV_STEPS - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

endmodule

// ----- rtl/beacon_tx_scheduler.sv -----
// Beacon transmit scheduler. Each request word is either a record operation
// (tuser 0), which stores now_ms as the last transmit time and returns nothing,
// or a tick (tuser 1), which returns one decision word: startup send, scheduled
// send, suppressed by neighbors or suppressed by interval. The block handles one
// word at a time. A record word passes check and returns to idle, where
// req_tready is high again. A suppressed tick passes check, decide and emit;
// a send adds commit, and with jitter enabled also the bit-serial remainder
// unit, which computes entropy mod the jitter maximum one dividend bit per
// cycle. A finished decision sits in an output register, so the next word is
// accepted while it waits for rsp_tready; a tick that finishes
// while that register is still full waits until it drains. Configuration
// registers are written through csr_we/csr_addr/csr_wdata and take effect at
// once; write them only while the block is idle.
module beacon_tx_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [bts_pkg::REQ_DATA_W-1:0]     req_tdata,  // now_ms[31:0], neighbor_count[39:32], entropy[71:40]
   input  logic                               req_tuser,  // op[0]
   // Response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bts_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // decision[1:0], zero fill[7:2]
   // Configuration port
   input  logic                               csr_we,
   input  logic [bts_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [bts_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   bts_pkg::dp_cmd_type    cmd;
   bts_pkg::dp_status_type status;

   // Sequencer
   bts_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .status     (status)
   );

   // State, compares, remainder unit and output register
   bts_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/bts_checker.sv -----
module bts_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic                               req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bts_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   // A stalled response word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response word changed while stalled");

   // The padding above the decision is always zero.
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[7:2] == 6'd0))
      else $error("response padding is not zero");

   // A record word never produces a response.
   a_record_silent: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == bts_pkg::OP_RECORD) |=> !$rose(rsp_tvalid))
      else $error("record word produced a response");

   // The block works on one word at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted in back-to-back cycles");

endmodule

bind beacon_tx_scheduler bts_checker u_bts_checker (.*);

// ----- bench/beacon_tx_scheduler_test.sv -----
`timescale 1ns / 1ps

// Scoreboard for the beacon scheduler. It keeps its own copy of the scheduler
// state and registers, predicts the decision for every accepted tick and
// compares the decision words that come back in order.
class decision_scoreboard;
   bit [30:0] gap_base;
   bit [30:0] jitter_mod;
   bit [31:0] startup_window_ms;
   bit [7:0]  burst_len;
   bit [7:0]  suppress_nbrs;

   bit        startup_over;
   bit [7:0]  burst_sent;
   bit [31:0] last_send_ms;
   bit [31:0] min_gap_ms;

   bts_pkg::decision_type expected_q[$];
   int errors;

   function new();
      gap_base          = bts_pkg::RST_INTERVAL;
      jitter_mod        = bts_pkg::RST_JITTER_MAX;
      startup_window_ms = bts_pkg::RST_STARTUP_WIN;
      burst_len         = bts_pkg::RST_BURST_LEN;
      suppress_nbrs     = bts_pkg::RST_SUPPRESS_NBRS;
      startup_over      = 1'b0;
      burst_sent        = '0;
      last_send_ms      = '0;
      min_gap_ms        = '0;
      errors            = 0;
   endfunction

   // Registers keep only their low bits, as the hardware does.
   function void set_register(logic [bts_pkg::CSR_ADDR_W-1:0] idx, bit [31:0] value);
      case (idx)
         bts_pkg::REG_INTERVAL:      gap_base = value[30:0];
         bts_pkg::REG_JITTER_MAX:    jitter_mod = value[30:0];
         bts_pkg::REG_STARTUP_WIN:   startup_window_ms = value;
         bts_pkg::REG_BURST_LEN:     burst_len = value[7:0];
         bts_pkg::REG_SUPPRESS_NBRS: suppress_nbrs = value[7:0];
         default: ;
      endcase
   endfunction

   // A send stores the time and arms the gap: interval plus entropy mod jitter.
   function void log_send(bit [31:0] now_val, bit [31:0] ent);
      bit [31:0] jit;
      jit = (jitter_mod != 0) ? ent % {1'b0, jitter_mod} : 32'd0;
      last_send_ms = now_val;
      min_gap_ms = {1'b0, gap_base} + jit;
   endfunction

   function void note_request(logic op, bit [31:0] now_val, bit [7:0] nbrs, bit [31:0] ent);
      bit [31:0] elapsed;
      // A record word only moves the last transmit time.
      if (op == bts_pkg::OP_RECORD) begin
         last_send_ms = now_val;
         return;
      end
      // Startup ends on the window or once the burst is complete.
      if (!startup_over && (now_val >= startup_window_ms || burst_sent >= burst_len))
         startup_over = 1'b1;
      if (!startup_over) begin
         burst_sent = burst_sent + 8'd1;
         if (burst_sent >= burst_len)
            startup_over = 1'b1;
         log_send(now_val, ent);
         expected_q.push_back(bts_pkg::DEC_STARTUP);
         return;
      end
      if (nbrs >= suppress_nbrs) begin
         expected_q.push_back(bts_pkg::DEC_NEIGHBORS);
         return;
      end
      // A zero last transmit time skips the gap test; elapsed time wraps.
      elapsed = now_val - last_send_ms;
      if (last_send_ms != 0 && elapsed < min_gap_ms) begin
         expected_q.push_back(bts_pkg::DEC_INTERVAL);
         return;
      end
      log_send(now_val, ent);
      expected_q.push_back(bts_pkg::DEC_SCHEDULED);
   endfunction

   function void note_error(string msg);
      errors++;
      if (errors <= 10)
         $display("%0t: %s", $realtime, msg);
   endfunction

   function void check_decision(bts_pkg::decision_type got);
      bts_pkg::decision_type want;
      if (expected_q.size() == 0) begin
         note_error($sformatf("decision %s with none outstanding", got.name()));
         return;
      end
      want = expected_q.pop_front();
      if (got != want)
         note_error($sformatf("decision expected %s, got %s", want.name(), got.name()));
   endfunction
endclass

module beacon_tx_scheduler_test;
   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [bts_pkg::REQ_DATA_W-1:0]    req_tdata = '0;  // now_ms, neighbor_count, entropy
   logic                              req_tuser = 1'b0;  // op
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b0;
   logic [bts_pkg::RSP_DATA_W-1:0]    rsp_tdata;  // decision, zero fill
   logic                              csr_we = 1'b0;
   logic [bts_pkg::CSR_ADDR_W-1:0]    csr_addr = '0;
   logic [bts_pkg::CSR_DATA_W-1:0]    csr_wdata = '0;

   decision_scoreboard sb;
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   bit [31:0]   now_cursor = '0;

   beacon_tx_scheduler u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 0;
   end

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Every decision word taken by the receiver is checked in order.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_decision(bts_pkg::decision_type'(rsp_tdata[1:0]));
   end

   // Present one request word, with random idle cycles ahead of it, and hand
   // it to the scoreboard once it is accepted. Valid stays high afterwards.
   task automatic send_word(logic op, bit [31:0] now_val, bit [7:0] nbrs, bit [31:0] ent);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {ent, nbrs, now_val};
      do @(posedge clock); while (!req_tready);
      sb.note_request(op, now_val, nbrs, ent);
   endtask

   // Hold off the sender until every decision is back, then let a record
   // word still in flight finish.
   task automatic settle();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (sb.expected_q.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   // Write all five registers; the unused top bit of the 31-bit ones is random.
   task automatic program_regs(bit [30:0] interval, bit [30:0] jitter, bit [31:0] window,
                               bit [7:0] burst, bit [7:0] suppress);
      logic [bts_pkg::CSR_ADDR_W-1:0] addrs [5];
      bit [31:0] vals [5];
      addrs = '{bts_pkg::REG_INTERVAL, bts_pkg::REG_JITTER_MAX, bts_pkg::REG_STARTUP_WIN,
                bts_pkg::REG_BURST_LEN, bts_pkg::REG_SUPPRESS_NBRS};
      vals  = '{{1'($urandom_range(1)), interval}, {1'($urandom_range(1)), jitter}, window,
                {24'($urandom), burst}, {24'($urandom), suppress}};
      for (int i = 0; i < 5; i++) begin
         csr_we    <= 1'b1;
         csr_addr  <= addrs[i];
         csr_wdata <= vals[i];
         @(posedge clock);
         sb.set_register(addrs[i], vals[i]);
      end
      csr_we <= 1'b0;
   endtask

   // One random word. Time moves in small steps, in steps near the armed gap or in
   // random steps, and the neighbor count sits near the threshold half of the time.
   task automatic random_word();
      bit [31:0] step;
      bit [31:0] ent;
      bit [31:0] scale;
      int        nbr_pick;
      bit [7:0]  nbrs;
      if ($urandom_range(9) == 0) begin
         if ($urandom_range(19) == 0)
            now_cursor = '0;
         else if ($urandom_range(1) == 0)
            now_cursor = $urandom;
         send_word(bts_pkg::OP_RECORD, now_cursor, 8'($urandom), $urandom);
         return;
      end
      scale = {1'b0, sb.gap_base} + {1'b0, sb.jitter_mod};
      case ($urandom_range(9))
         0, 1:    step = $urandom_range(3);
         2, 3, 4: step = sb.min_gap_ms + $urandom_range(4) - 2;
         7:       step = $urandom;
         default: step = $urandom_range(scale);
      endcase
      now_cursor = now_cursor + step;
      if ($urandom_range(1) == 0) begin
         nbr_pick = int'(sb.suppress_nbrs) + int'($urandom_range(2)) - 1;
         if (nbr_pick < 0) nbr_pick = 0;
         if (nbr_pick > 255) nbr_pick = 255;
         nbrs = 8'(nbr_pick);
      end else begin
         nbrs = 8'($urandom_range(255));
      end
      case ($urandom_range(15))
         0:       ent = '0;
         1:       ent = '1;
         default: ent = $urandom;
      endcase
      send_word(bts_pkg::OP_TICK, now_cursor, nbrs, ent);
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      program_regs(31'd100, 31'd7, 32'd10000, 8'd3, 8'd4);

      // Startup burst: neighbors are ignored, a send at time zero counts.
      send_word(bts_pkg::OP_RECORD, 32'd50, 8'd0, 32'd0);
      send_word(bts_pkg::OP_TICK, 32'd0, 8'd255, 32'hFFFF_FFFF);
      send_word(bts_pkg::OP_TICK, 32'd5, 8'd0, 32'd0);
      // Reaching the window exactly ends startup; that tick follows normal rules.
      send_word(bts_pkg::OP_TICK, 32'd10000, 8'd3, 32'd12345);
      send_word(bts_pkg::OP_TICK, 32'd10001, 8'd4, $urandom);
      send_word(bts_pkg::OP_TICK, 32'd10050, 8'd0, $urandom);
      // One short of the gap, then exactly on it.
      send_word(bts_pkg::OP_TICK, sb.last_send_ms + sb.min_gap_ms - 1, 8'd0, $urandom);
      send_word(bts_pkg::OP_TICK, sb.last_send_ms + sb.min_gap_ms, 8'd0, $urandom);
      // A zero last transmit time skips the gap test.
      send_word(bts_pkg::OP_RECORD, 32'd0, 8'hFF, 32'hFFFF_FFFF);
      send_word(bts_pkg::OP_TICK, 32'd1, 8'd0, $urandom);
      // Elapsed time across the wrap is short, a time before the last send is long.
      send_word(bts_pkg::OP_RECORD, 32'hFFFF_FFF0, 8'd0, 32'd0);
      send_word(bts_pkg::OP_TICK, 32'd5, 8'd0, $urandom);
      send_word(bts_pkg::OP_RECORD, 32'd1000, 8'd0, 32'd0);
      send_word(bts_pkg::OP_TICK, 32'd500, 8'd0, $urandom);
      send_word(bts_pkg::OP_TICK, 32'hFFFF_FFFF, 8'd255, 32'd0);
      send_word(bts_pkg::OP_TICK, 32'hFFFF_FFFF, 8'd0, 32'hFFFF_FFFF);
      now_cursor = 32'hFFFF_FFFF;
      settle();

      // Random phases, each with its own register setting and one of four idle patterns.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: program_regs(31'd100, 31'd7, 32'd0, 8'd0, 8'd4);
            1: program_regs(31'd0, 31'd0, 32'hFFFF_FFFF, 8'd255, 8'd255);
            2: program_regs(31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'd0, 8'd1, 8'd0);
            3: program_regs(31'd1000, 31'd1, $urandom, 8'($urandom), 8'd8);
            4: program_regs(31'd500, 31'd300, 32'd10000, 8'd3, 8'd200);
            5: program_regs(31'($urandom_range(1, 5000)), 31'($urandom_range(5000)),
                            $urandom, 8'($urandom), 8'($urandom));
            6: program_regs(31'h7FFF_FFFF, 31'd0, 32'd12345, 8'd128, 8'd128);
            default: program_regs(bts_pkg::RST_INTERVAL, bts_pkg::RST_JITTER_MAX,
                                  bts_pkg::RST_STARTUP_WIN, bts_pkg::RST_BURST_LEN,
                                  bts_pkg::RST_SUPPRESS_NBRS);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         for (int n = 0; n < 212; n++)
            random_word();
         settle();
      end

      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("beacon_tx_scheduler_test: done, clean");
      end else begin
         $display("beacon_tx_scheduler_test: done, errors");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #10_000_000;
      $display("beacon_tx_scheduler_test: done, errors");
      $finish;
   end
endmodule
